// ===== rtl/wstd_pkg.sv =====
// shared types and constants for the window statistics threshold detector
package wstd_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int INTERVAL_W = 16;
  localparam int WLEN_W     = 5;
  localparam int DEVT_W     = 11;
  localparam int DELT_W     = 10;
  localparam int CMP_W      = 19;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(8);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_INTERVAL = 3'd0,
    CFG_WINDOW_LENGTH   = 3'd1,
    CFG_DEV_THRESHOLD   = 3'd2,
    CFG_DELTA_THRESHOLD = 3'd3,
    CFG_DIRECTION       = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_FIN
  } wstd_state_t;

endpackage

// ===== rtl/wstd_in_if.sv =====
// input channel carrying one converter reading per transaction
interface wstd_in_if
  import wstd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

// ===== rtl/wstd_out_if.sv =====
// result channel carrying the window statistics of one tick
interface wstd_out_if
  import wstd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic                          sampled;
  logic [SAMPLE_BITS-1:0]        newest;
  logic [SAMPLE_BITS-1:0]        average;
  logic [SAMPLE_BITS-1:0]        window_max;
  logic [SAMPLE_BITS-1:0]        window_min;
  logic signed [SAMPLE_BITS:0]   deviation;
  logic [SAMPLE_BITS-1:0]        spread;
  logic signed [SAMPLE_BITS:0]   step_change;
  logic                          firing;

  modport source (
    output valid, output sampled, output newest, output average, output window_max,
    output window_min, output deviation, output spread, output step_change,
    output firing, input ready
  );
  modport sink (
    input valid, input sampled, input newest, input average, input window_max,
    input window_min, input deviation, input spread, input step_change,
    input firing, output ready
  );
endinterface

// ===== rtl/window_stats_threshold_detector_unit.sv =====
// moving window statistics and threshold detector, top level
//
// in_ch takes one reading per millisecond tick; each transaction gives exactly
// one result transaction on out_ch with newest, average, max, min, deviation,
// spread, step change and a firing flag. cfg_we/cfg_idx/cfg_wdata write the
// five setup registers (interval, length, deviation threshold, delta
// threshold, direction); the user must do so only while the block is idle,
// which the block itself does not enforce. The history lives in a circular
// buffer memory; one shared adder walks the window (one entry a cycle, read
// data registered) and then runs a restoring divide of the sum by the
// length, one quotient bit a cycle.
// in_ch.ready is low from the input transaction until the block is back in
// idle, so a new reading is taken only after the last one has been walked,
// divided and finished.
// A finished result sits in the output register while the next reading is
// already taken; if the receiver still stalls at the end of that next divide,
// the block waits there.
// Reset clears the registers to their defaults and the history to empty; the
// first reading after reset stands for the whole window, no clearing pass.
module window_stats_threshold_detector_unit
  import wstd_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  wstd_in_if.sink               in_ch,
  wstd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int AW     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W  = SB + LEN_W;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam logic [AW-1:0]     LAST_ADDR = AW'(WINDOW_MAX - 1);
  localparam logic [LEN_W-1:0]  FULL_CNT  = LEN_W'(WINDOW_MAX);
  localparam logic [DCNT_W-1:0] LAST_DIV  = DCNT_W'(SUM_W - 1);

  // setup registers
  logic [INTERVAL_W-1:0]    cfg_interval_r;
  logic [WLEN_W-1:0]        cfg_wlen_r;
  logic signed [DEVT_W-1:0] cfg_devt_r;
  logic [DELT_W-1:0]        cfg_delt_r;
  logic                     cfg_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_interval_r <= '0;
      cfg_wlen_r     <= WLEN_RESET;
      cfg_devt_r     <= '0;
      cfg_delt_r     <= '0;
      cfg_dir_r      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_SAMPLE_INTERVAL: cfg_interval_r <= cfg_wdata[INTERVAL_W-1:0];
        CFG_WINDOW_LENGTH:   cfg_wlen_r     <= cfg_wdata[WLEN_W-1:0];
        CFG_DEV_THRESHOLD:   cfg_devt_r     <= $signed(cfg_wdata[DEVT_W-1:0]);
        CFG_DELTA_THRESHOLD: cfg_delt_r     <= cfg_wdata[DELT_W-1:0];
        CFG_DIRECTION:       cfg_dir_r      <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  wstd_state_t           state_r, state_nxt;
  logic                  primed_r;
  logic [INTERVAL_W-1:0] elapsed_r;
  logic [AW-1:0]         head_r;
  logic [LEN_W-1:0]      cnt_r;
  logic [SB-1:0]         fill_r;
  logic [LEN_W-1:0]      len_r;
  logic                  sampled_r;
  logic [AW-1:0]         addr_r;
  logic [LEN_W-1:0]      issue_cnt_r;
  logic [LEN_W-1:0]      proc_cnt_r;
  logic                  pend_r;
  logic                  pend_real_r;
  logic [SB-1:0]         rd_q_r;
  logic [SUM_W-1:0]      sum_r;
  logic [SB-1:0]         newest_r, prev_r, hi_r, lo_r;
  logic [SUM_W-1:0]      quo_r;
  logic [LEN_W-1:0]      rem_r;
  logic [DCNT_W-1:0]     div_cnt_r;
  logic                  out_valid_r;

  logic [SB-1:0] mem [WINDOW_MAX];

  // state machine outputs
  logic             in_ready;
  logic             alu_sub;
  logic [SUM_W-1:0] alu_a, alu_b;
  logic [SUM_W:0]   alu_y;

  // accept-side logic
  logic                  in_acc;
  logic [INTERVAL_W-1:0] elapsed_inc;
  logic                  take;
  logic [AW-1:0]         head_inc;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [LEN_W-1:0]      len_c;

  assign in_acc      = in_ch.valid && in_ready;
  assign elapsed_inc = (elapsed_r == '1) ? elapsed_r : elapsed_r + 1'b1;
  assign take        = elapsed_inc >= cfg_interval_r;
  assign head_inc    = (head_r == LAST_ADDR) ? '0 : head_r + 1'b1;
  assign mem_we      = in_acc && (!primed_r || take);
  assign mem_waddr   = primed_r ? head_inc : '0;

  always_comb begin
    if (cfg_wlen_r == '0) begin
      len_c = LEN_W'(1);
    end else if (32'(cfg_wlen_r) > WINDOW_MAX) begin
      len_c = FULL_CNT;
    end else begin
      len_c = LEN_W'(cfg_wlen_r);
    end
  end

  // walk and divide signals
  logic [SB-1:0]    s_cur;
  logic             issue;
  logic             walk_last;
  logic [LEN_W:0]   div_shift;
  logic             out_free;

  assign s_cur     = pend_real_r ? rd_q_r : fill_r;
  assign issue     = issue_cnt_r < len_r;
  assign walk_last = pend_r && ((proc_cnt_r + 1'b1) == len_r);
  assign div_shift = {rem_r, quo_r[SUM_W-1]};
  assign out_free  = !out_valid_r || out_ch.ready;

  // shared adder: accumulates in the walk, trial-subtracts in the divide
  assign alu_y = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (SUM_W+1)'(alu_sub);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_WALK;
      ST_WALK: if (walk_last) state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == LAST_DIV) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    alu_sub  = 1'b0;
    alu_a    = sum_r;
    alu_b    = SUM_W'(s_cur);
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_DIV: begin
        alu_sub = 1'b1;
        alu_a   = SUM_W'(div_shift);
        alu_b   = SUM_W'(len_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      elapsed_r   <= '0;
      head_r      <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        if (!primed_r) begin
          primed_r  <= 1'b1;
          head_r    <= '0;
          cnt_r     <= LEN_W'(1);
          elapsed_r <= '0;
        end else if (take) begin
          head_r    <= head_inc;
          cnt_r     <= (cnt_r == FULL_CNT) ? cnt_r : cnt_r + 1'b1;
          elapsed_r <= '0;
        end else begin
          elapsed_r <= elapsed_inc;
        end
      end
      pend_r <= (state_r == ST_WALK) && issue;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // history memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_ch.reading;
    end
    rd_q_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!primed_r) begin
            fill_r <= in_ch.reading;
          end
          sampled_r   <= !primed_r || take;
          len_r       <= len_c;
          addr_r      <= mem_we ? mem_waddr : head_r;
          issue_cnt_r <= '0;
          proc_cnt_r  <= '0;
          sum_r       <= '0;
        end
      end
      ST_WALK: begin
        if (issue) begin
          pend_real_r <= issue_cnt_r < cnt_r;
          addr_r      <= (addr_r == '0) ? LAST_ADDR : addr_r - 1'b1;
          issue_cnt_r <= issue_cnt_r + 1'b1;
        end
        if (pend_r) begin
          sum_r      <= alu_y[SUM_W-1:0];
          proc_cnt_r <= proc_cnt_r + 1'b1;
          if (proc_cnt_r == '0) begin
            newest_r <= s_cur;
            hi_r     <= s_cur;
            lo_r     <= s_cur;
          end else begin
            if (s_cur > hi_r) hi_r <= s_cur;
            if (s_cur < lo_r) lo_r <= s_cur;
          end
          if (proc_cnt_r == LEN_W'(1)) begin
            prev_r <= s_cur;
          end
        end
        if (walk_last) begin
          quo_r     <= alu_y[SUM_W-1:0];
          rem_r     <= '0;
          div_cnt_r <= '0;
        end
      end
      ST_DIV: begin
        // carry out of the trial subtract means the divisor fits
        rem_r     <= alu_y[SUM_W] ? alu_y[LEN_W-1:0] : div_shift[LEN_W-1:0];
        quo_r     <= {quo_r[SUM_W-2:0], alu_y[SUM_W]};
        div_cnt_r <= div_cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  // result evaluation
  logic [SB-1:0]           avg_c, dn_c, up_c, spread_c;
  logic signed [SB:0]      dev_c, step_c;
  logic signed [CMP_W-1:0] thr_x, dev_x, thr_abs, dev_abs;
  logic                    by_dev, by_delta;

  assign avg_c    = quo_r[SB-1:0];
  assign dev_c    = $signed({1'b0, newest_r}) - $signed({1'b0, avg_c});
  assign dn_c     = newest_r - lo_r;
  assign up_c     = hi_r - newest_r;
  assign spread_c = (!cfg_dir_r && (up_c > dn_c)) ? up_c : dn_c;
  assign step_c   = (len_r == LEN_W'(1)) ? '0
                  : $signed({1'b0, prev_r}) - $signed({1'b0, newest_r});
  assign thr_x    = CMP_W'(cfg_devt_r);
  assign dev_x    = CMP_W'(dev_c);
  assign thr_abs  = (thr_x < 0) ? -thr_x : thr_x;
  assign dev_abs  = (dev_x < 0) ? -dev_x : dev_x;

  always_comb begin
    by_dev = 1'b0;
    if (cfg_devt_r != '0) begin
      if (cfg_dir_r && (thr_x < 0) && (dev_x < 0)) begin
        by_dev = thr_x > dev_x;
      end else begin
        by_dev = thr_abs < dev_abs;
      end
    end
  end

  assign by_delta = (cfg_delt_r != '0) && ((newest_r == lo_r) || (newest_r == hi_r))
                  && (32'(spread_c) >= 32'(cfg_delt_r));

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_ch.sampled     <= sampled_r;
      out_ch.newest      <= newest_r;
      out_ch.average     <= avg_c;
      out_ch.window_max  <= hi_r;
      out_ch.window_min  <= lo_r;
      out_ch.deviation   <= dev_c;
      out_ch.spread      <= spread_c;
      out_ch.step_change <= step_c;
      out_ch.firing      <= by_dev || by_delta;
    end
  end

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= WINDOW_MAX)
    else $error("history fill count beyond window depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(head_r) < WINDOW_MAX)
    else $error("circular buffer head out of range");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < len_r)
    else $error("divide remainder not below divisor");

  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> lo_r <= hi_r)
    else $error("window min above window max");

  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not presented");

endmodule

// ===== tb/window_stats_threshold_detector_unit_tb.sv =====
// self-checking testbench for the moving window statistics threshold detector
`timescale 1ns / 1ps

module window_stats_threshold_detector_unit_tb;
  import wstd_pkg::*;

  localparam int TOTAL_TICKS = 1350;
  localparam int STUCK_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int DIRECTED_ROWS = 37;

  typedef struct packed {
    logic               sampled;
    logic [9:0]         newest;
    logic [9:0]         average;
    logic [9:0]         window_max;
    logic [9:0]         window_min;
    logic signed [10:0] deviation;
    logic [9:0]         spread;
    logic signed [10:0] step_change;
    logic               firing;
  } tick_stats_t;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_TICK,
    ROW_PINNED
  } row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    cfg_idx_t    idx;
    int          value;
    tick_stats_t want;
  } stim_row_t;

  typedef struct packed {
    logic        pinned;
    tick_stats_t want;
  } tick_note_t;

  localparam tick_stats_t NO_STATS = '0;

  // typed rows: after reset, extremes and clamped lengths
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_PINNED, CFG_SAMPLE_INTERVAL, 1023,
      '{1'b1, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 11'sd0, 10'd0, 11'sd0, 1'b0}},
    '{ROW_PINNED, CFG_SAMPLE_INTERVAL, 0,
      '{1'b1, 10'd0, 10'd895, 10'd1023, 10'd0, -11'sd895, 10'd1023, 11'sd1023, 1'b0}},
    '{ROW_CFG,    CFG_WINDOW_LENGTH,   1,     NO_STATS},
    '{ROW_PINNED, CFG_SAMPLE_INTERVAL, 512,
      '{1'b1, 10'd512, 10'd512, 10'd512, 10'd512, 11'sd0, 10'd0, 11'sd0, 1'b0}},
    '{ROW_CFG,    CFG_WINDOW_LENGTH,   0,     NO_STATS},
    '{ROW_PINNED, CFG_SAMPLE_INTERVAL, 5,
      '{1'b1, 10'd5, 10'd5, 10'd5, 10'd5, 11'sd0, 10'd0, 11'sd0, 1'b0}},
    '{ROW_CFG,    CFG_WINDOW_LENGTH,   31,    NO_STATS},
    '{ROW_CFG,    CFG_SAMPLE_INTERVAL, 3,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 100,   NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 200,   NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 300,   NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 400,   NO_STATS},
    '{ROW_CFG,    CFG_SAMPLE_INTERVAL, 1,     NO_STATS},
    '{ROW_CFG,    CFG_DEV_THRESHOLD,   -1024, NO_STATS},
    '{ROW_CFG,    CFG_DIRECTION,       1,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 0,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 1023,  NO_STATS},
    '{ROW_CFG,    CFG_DIRECTION,       0,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 0,     NO_STATS},
    '{ROW_CFG,    CFG_DEV_THRESHOLD,   1023,  NO_STATS},
    '{ROW_CFG,    CFG_DELTA_THRESHOLD, 1023,  NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 1023,  NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 0,     NO_STATS},
    '{ROW_CFG,    CFG_DEV_THRESHOLD,   1,     NO_STATS},
    '{ROW_CFG,    CFG_DELTA_THRESHOLD, 1,     NO_STATS},
    '{ROW_CFG,    CFG_WINDOW_LENGTH,   2,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 700,   NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 300,   NO_STATS},
    '{ROW_CFG,    CFG_SAMPLE_INTERVAL, 65535, NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 1,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 1022,  NO_STATS},
    '{ROW_CFG,    CFG_SAMPLE_INTERVAL, 0,     NO_STATS},
    '{ROW_CFG,    CFG_DIRECTION,       1,     NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 341,   NO_STATS},
    '{ROW_TICK,   CFG_SAMPLE_INTERVAL, 682,   NO_STATS},
    '{ROW_CFG,    CFG_DELTA_THRESHOLD, 0,     NO_STATS},
    '{ROW_CFG,    CFG_DEV_THRESHOLD,   0,     NO_STATS}
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wstd_in_if  in_ch ();
  wstd_out_if out_ch ();

  window_stats_threshold_detector_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // predictor copy of the window and setup registers
  logic [9:0]         hist_q [16];
  logic               primed_q;
  logic [15:0]        elapsed_q;
  logic [15:0]        interval_q;
  logic [4:0]         wlen_q;
  logic signed [10:0] devthr_q;
  logic [9:0]         deltathr_q;
  logic               dirsens_q;

  tick_stats_t pending_stats [$];
  tick_note_t  tick_notes [$];
  int          mismatches;
  int          ticks_sent;
  int          stuck_cycles;
  int          last_reading;
  bit          block_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic tick_stats_t advance_window(logic [9:0] rd);
    tick_stats_t r;
    int len, total, hi, lo, cur, avg, dev, spr, up, stp, thr;
    bit by_dev, by_delta;
    r.sampled = 1'b0;
    if (!primed_q) begin
      foreach (hist_q[i]) hist_q[i] = rd;
      primed_q = 1'b1;
      elapsed_q = '0;
      r.sampled = 1'b1;
    end else begin
      if (elapsed_q != 16'hFFFF) elapsed_q++;
      if (elapsed_q >= interval_q) begin
        for (int i = 15; i > 0; i--) hist_q[i] = hist_q[i-1];
        hist_q[0] = rd;
        elapsed_q = '0;
        r.sampled = 1'b1;
      end
    end
    len = int'(wlen_q);
    if (len < 1) len = 1;
    if (len > 16) len = 16;
    total = 0;
    hi = 0;
    lo = int'(hist_q[0]);
    for (int i = 0; i < len; i++) begin
      total += int'(hist_q[i]);
      if (int'(hist_q[i]) > hi) hi = int'(hist_q[i]);
      if (int'(hist_q[i]) < lo) lo = int'(hist_q[i]);
    end
    avg = total / len;
    cur = int'(hist_q[0]);
    dev = cur - avg;
    spr = cur - lo;
    if (!dirsens_q) begin
      up = hi - cur;
      if (up > spr) spr = up;
    end
    stp = (len == 1) ? 0 : int'(hist_q[1]) - cur;
    thr = int'(devthr_q);
    by_dev = 1'b0;
    if (thr != 0) begin
      // a negative bound only counts as signed in direction-sensitive mode
      if (dirsens_q && thr < 0 && dev < 0) by_dev = thr > dev;
      else by_dev = ((thr < 0) ? -thr : thr) < ((dev < 0) ? -dev : dev);
    end
    by_delta = (deltathr_q != 0) && (cur == lo || cur == hi) && (spr >= int'(deltathr_q));
    r.newest      = 10'(cur);
    r.average     = 10'(avg);
    r.window_max  = 10'(hi);
    r.window_min  = 10'(lo);
    r.deviation   = 11'(dev);
    r.spread      = 10'(spr);
    r.step_change = 11'(stp);
    r.firing      = by_dev || by_delta;
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t ERROR %s: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_stats(tick_stats_t got, tick_stats_t want);
    if (got.sampled !== want.sampled)
      flag_mismatch("sampled", got.sampled, want.sampled);
    if (got.newest !== want.newest)
      flag_mismatch("newest", got.newest, want.newest);
    if (got.average !== want.average)
      flag_mismatch("average", got.average, want.average);
    if (got.window_max !== want.window_max)
      flag_mismatch("window_max", got.window_max, want.window_max);
    if (got.window_min !== want.window_min)
      flag_mismatch("window_min", got.window_min, want.window_min);
    if (got.deviation !== want.deviation)
      flag_mismatch("deviation", int'(got.deviation), int'(want.deviation));
    if (got.spread !== want.spread)
      flag_mismatch("spread", got.spread, want.spread);
    if (got.step_change !== want.step_change)
      flag_mismatch("step_change", int'(got.step_change), int'(want.step_change));
    if (got.firing !== want.firing)
      flag_mismatch("firing", got.firing, want.firing);
  endtask

  // scoreboard: check results first, then predict the newly accepted reading
  always @(posedge clk) begin
    tick_stats_t got;
    tick_note_t note;
    tick_stats_t predicted;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.sampled     = out_ch.sampled;
        got.newest      = out_ch.newest;
        got.average     = out_ch.average;
        got.window_max  = out_ch.window_max;
        got.window_min  = out_ch.window_min;
        got.deviation   = out_ch.deviation;
        got.spread      = out_ch.spread;
        got.step_change = out_ch.step_change;
        got.firing      = out_ch.firing;
        if (pending_stats.size() == 0)
          flag_mismatch("result with nothing pending, newest", got.newest, 0);
        else
          compare_stats(got, pending_stats.pop_front());
      end
      if (in_ch.valid && in_ch.ready) begin
        note = (tick_notes.size() != 0) ? tick_notes.pop_front() : '0;
        predicted = advance_window(in_ch.reading);
        pending_stats.push_back(note.pinned ? note.want : predicted);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("window_stats_threshold_detector_unit_tb failed");
        $finish;
      end
    end
  end

  // receiver: switches between randomly chosen stall styles
  initial begin
    int style;
    int style_age;
    int stall_run;
    style = 0;
    style_age = 0;
    stall_run = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      style_age++;
      if (style_age >= 300) begin
        style_age = 0;
        style = $urandom_range(0, 3);
      end
      case (style)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: begin
          if (stall_run > 0) begin
            stall_run--;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 40);
          end
        end
        default: out_ch.ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // drop valid and wait until every pending result is back
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    block_idle = 1'b1;
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    if (!block_idle) settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= 16'(value);
    case (idx)
      CFG_SAMPLE_INTERVAL: interval_q = 16'(value);
      CFG_WINDOW_LENGTH:   wlen_q = 5'(value);
      CFG_DEV_THRESHOLD:   devthr_q = 11'(value);
      CFG_DELTA_THRESHOLD: deltathr_q = 10'(value);
      CFG_DIRECTION:       dirsens_q = 1'(value);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays high on return so back-to-back transactions need no gap
  task automatic send_tick(logic [9:0] rd, logic pinned, tick_stats_t want);
    cfg_we         <= 1'b0;
    in_ch.valid    <= 1'b1;
    in_ch.reading  <= rd;
    tick_notes.push_back('{pinned, want});
    block_idle = 1'b0;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
  endtask

  task automatic random_setup();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = 0;
      5, 6, 7:       v = $urandom_range(1, 4);
      8:             v = $urandom_range(5, 20);
      default:       v = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(21, 65535);
    endcase
    write_reg(CFG_SAMPLE_INTERVAL, v);
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = $urandom_range(17, 31);
      2:       v = 16;
      default: v = $urandom_range(1, 16);
    endcase
    write_reg(CFG_WINDOW_LENGTH, v);
    case ($urandom_range(0, 7))
      0:       v = 0;
      1:       v = -1024;
      2:       v = 1023;
      3:       v = int'($urandom_range(0, 2047)) - 1024;
      default: v = int'($urandom_range(0, 80)) - 40;
    endcase
    write_reg(CFG_DEV_THRESHOLD, v);
    case ($urandom_range(0, 5))
      0:       v = 0;
      1:       v = 1023;
      2:       v = $urandom_range(0, 1023);
      default: v = $urandom_range(1, 60);
    endcase
    write_reg(CFG_DELTA_THRESHOLD, v);
    write_reg(CFG_DIRECTION, $urandom_range(0, 1));
  endtask

  // mostly a drifting signal, with jumps to the rails and full-range noise
  function automatic logic [9:0] next_reading();
    int r;
    case ($urandom_range(0, 9))
      6, 7:    r = $urandom_range(0, 1023);
      8:       r = 0;
      9:       r = 1023;
      default: r = last_reading + int'($urandom_range(0, 32)) - 16;
    endcase
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    last_reading = r;
    return 10'(r);
  endfunction

  initial begin
    int burst_left;
    int gap;
    int phase_len;
    mismatches   = 0;
    ticks_sent   = 0;
    last_reading = 512;
    block_idle   = 1'b1;
    burst_left   = 0;
    primed_q     = 1'b0;
    elapsed_q    = '0;
    interval_q   = '0;
    wlen_q       = WLEN_RESET;
    devthr_q     = '0;
    deltathr_q   = '0;
    dirsens_q    = 1'b0;
    foreach (hist_q[i]) hist_q[i] = '0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.reading <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_SAMPLE_INTERVAL;
    cfg_wdata     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      else
        send_tick(10'(directed_rows[i].value), directed_rows[i].kind == ROW_PINNED,
                  directed_rows[i].want);
    end

    while (ticks_sent < TOTAL_TICKS) begin
      random_setup();
      phase_len = $urandom_range(15, 60);
      repeat (phase_len) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 24);
        end
        send_tick(next_reading(), 1'b0, NO_STATS);
        burst_left--;
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("window_stats_threshold_detector_unit_tb passed");
    end else begin
      $display("window_stats_threshold_detector_unit_tb failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/wstd_pkg.sv
rtl/wstd_in_if.sv
rtl/wstd_out_if.sv
rtl/window_stats_threshold_detector_unit.sv
tb/window_stats_threshold_detector_unit_tb.sv
